FILE: src/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg
// Shared types, constants and helpers of the segment pattern player.
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam int DEF_SAMPLE_DEPTH  = 1024;
    localparam int DEF_SEGMENT_COUNT = 16;

    localparam int VALUE_W = 16;
    localparam int INDEX_W = 10;
    localparam int SEG_W   = 4;
    localparam int SCALE_W = 16;
    localparam int COUNT_W = 11;
    localparam int CFGI_W  = 3;

    localparam logic [CFGI_W-1:0] REG_SAMPLE_COUNT = 3'd0;
    localparam logic [CFGI_W-1:0] REG_STEP_TIME    = 3'd1;
    localparam logic [CFGI_W-1:0] REG_TIME_SCALE   = 3'd2;
    localparam logic [CFGI_W-1:0] REG_RAND_LOW     = 3'd3;
    localparam logic [CFGI_W-1:0] REG_RAND_HIGH    = 3'd4;
    localparam logic [CFGI_W-1:0] REG_RUN_REVERSE  = 3'd5;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_WR_SMP  = 3'd1,
        CMD_WR_SEG  = 3'd2,
        CMD_HOLD    = 3'd3,
        CMD_RELEASE = 3'd4,
        CMD_STOP    = 3'd5,
        CMD_JUMP    = 3'd6
    } t_cmd;

    typedef struct packed {
        t_cmd                       cmd;
        logic [INDEX_W-1:0]         index;
        logic signed [VALUE_W-1:0]  sample_value;
        logic [SEG_W-1:0]           sample_segment;
        logic                       segment_random;
        logic [SCALE_W-1:0]         segment_scale;
        logic                       sample_ok;
        logic                       segment_ok;
    } t_item;

    typedef struct packed {
        logic [COUNT_W-1:0]         sample_count;
        logic [15:0]                step_time;
        logic [15:0]                time_scale;
        logic signed [VALUE_W-1:0]  rand_low;
        logic signed [VALUE_W-1:0]  rand_high;
        logic                       run_reverse;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_CMP,
        ST_RD,
        ST_VAL,
        ST_MOD,
        ST_JRD,
        ST_JSEG
    } t_state;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

FILE: src/spp_ram.sv
// ----------------------------------------------------------------------------
// spp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module spp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/spp_mod.sv
// ----------------------------------------------------------------------------
// spp_mod
// Bit-serial remainder unit: 32-bit dividend by 16-bit divisor.
// ----------------------------------------------------------------------------
module spp_mod import spp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_rem
);

    logic [31:0] r_q, n_q;
    logic [16:0] r_r, n_r;
    logic [15:0] r_d;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_done, n_done;
    logic [16:0] shifted;

    always_comb begin
        shifted = {r_r[15:0], r_q[31]};
        n_q     = r_q;
        n_r     = r_r;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        if (i_start) begin
            n_q   = i_dividend;
            n_r   = '0;
            n_cnt = 6'd32;
        end else if (r_cnt != '0) begin
            n_q   = {r_q[30:0], 1'b0};
            n_r   = (shifted >= {1'b0, r_d}) ? shifted - {1'b0, r_d} : shifted;
            n_cnt = r_cnt - 6'd1;
            n_done = (r_cnt == 6'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_start) begin
            r_d <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_r[15:0];

endmodule

FILE: src/spp_front.sv
// ----------------------------------------------------------------------------
// spp_front
// Input side: accepts commands, checks indexes, two-entry command queue.
// ----------------------------------------------------------------------------
module spp_front import spp_pkg::*; #(
    parameter int SAMPLE_DEPTH  = DEF_SAMPLE_DEPTH,
    parameter int SEGMENT_COUNT = DEF_SEGMENT_COUNT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [2:0]                 i_cmd,
    input  logic [INDEX_W-1:0]         i_index,
    input  logic signed [VALUE_W-1:0]  i_sample_value,
    input  logic [SEG_W-1:0]           i_sample_segment,
    input  logic                       i_segment_random,
    input  logic [SCALE_W-1:0]         i_segment_scale,
    output logic                       o_item_valid,
    output t_item                      o_item,
    input  logic                       i_item_pop
);

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      item_in;
    logic       push_ok;

    always_comb begin
        item_in.cmd            = t_cmd'(i_cmd);
        item_in.index          = i_index;
        item_in.sample_value   = i_sample_value;
        item_in.sample_segment = i_sample_segment;
        item_in.segment_random = i_segment_random;
        item_in.segment_scale  = i_segment_scale;
        item_in.sample_ok      = (32'(i_index) < 32'(SAMPLE_DEPTH));
        item_in.segment_ok     = (32'(i_index) < 32'(SEGMENT_COUNT));
    end

    assign o_full       = (r_cnt == 2'd2);
    assign push_ok      = i_push && !o_full;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (i_item_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, i_item_pop};
        end
        if (push_ok) begin
            r_q[r_wp] <= item_in;
        end
    end

endmodule

FILE: src/spp_back.sv
// ----------------------------------------------------------------------------
// spp_back
// Execution side: tables, step timing, sample sequencing, result register.
// ----------------------------------------------------------------------------
module spp_back import spp_pkg::*; #(
    parameter int SAMPLE_DEPTH  = DEF_SAMPLE_DEPTH,
    parameter int SEGMENT_COUNT = DEF_SEGMENT_COUNT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_item_valid,
    input  t_item                      i_item,
    output logic                       o_item_pop,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic signed [VALUE_W-1:0]  o_out_value,
    output logic [INDEX_W-1:0]         o_out_sample,
    output logic [SEG_W-1:0]           o_out_segment,
    output logic                       o_stepped,
    output logic                       o_wrapped
);

    localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int SW = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
    localparam int CW = (AW > INDEX_W) ? AW : INDEX_W;

    t_state r_state, n_state;

    logic [AW-1:0]        r_cur;
    logic [SEG_W-1:0]     r_seg;
    logic [31:0]          r_tick;
    logic [39:0]          r_last;
    logic                 r_playing, r_paused, r_done;
    logic [VALUE_W-1:0]   r_held;
    logic [31:0]          r_noise;
    logic                 r_stepped, r_load_seg;
    logic [31:0]          r_prod1;
    logic [15:0]          r_sscale;
    logic [35:0]          r_t8;
    logic                 r_flags  [SEGMENT_COUNT];
    logic [SCALE_W-1:0]   r_scales [SEGMENT_COUNT];

    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_value;
    logic [CW-1:0]        r_out_sample;
    logic [SEG_W-1:0]     r_out_segment;
    logic                 r_out_stepped, r_out_wrapped;

    logic [VALUE_W-1:0]   store_rdata;
    logic [SEG_W-1:0]     map_rdata;
    logic                 ram_we;

    logic                 take;
    logic                 load_out;
    logic [VALUE_W-1:0]   out_val;
    logic [SEG_W-1:0]     seg_now;
    logic                 seg_rnd;
    logic [31:0]          noise_next;
    logic                 rng_empty;
    logic                 mod_start, mod_done;
    logic [15:0]          mod_rem;
    logic [15:0]          span;
    logic [31:0]          cnt_eff;
    logic                 due;
    logic [47:0]          prod2;

    spp_ram #(.WIDTH(VALUE_W), .DEPTH(SAMPLE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_item.index)),
        .i_wdata (i_item.sample_value),
        .i_raddr (r_cur),
        .o_rdata (store_rdata)
    );

    spp_ram #(.WIDTH(SEG_W), .DEPTH(SAMPLE_DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_item.index)),
        .i_wdata (i_item.sample_segment),
        .i_raddr (r_cur),
        .o_rdata (map_rdata)
    );

    spp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (noise_next),
        .i_divisor  (span),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // ticks wait for a free result register, other commands never do
    assign take = i_item_valid && (r_state == ST_IDLE)
                  && ((i_item.cmd != CMD_TICK) || !r_out_valid);

    assign seg_now    = r_load_seg ? map_rdata : r_seg;
    assign seg_rnd    = (32'(seg_now) < 32'(SEGMENT_COUNT)) && r_flags[SW'(seg_now)];
    assign noise_next = xorshift32(r_noise);
    assign rng_empty  = (i_cfg.rand_high <= i_cfg.rand_low);
    assign span       = 16'(17'(i_cfg.rand_high) - 17'(i_cfg.rand_low));
    assign prod2      = 48'(r_prod1) * 48'(r_sscale);
    assign due        = ({r_tick, 8'd0} > (41'(r_last) + 41'(r_t8)));

    always_comb begin
        cnt_eff = 32'(i_cfg.sample_count);
        if (cnt_eff == '0) begin
            cnt_eff = 32'd1;
        end
        if (cnt_eff > 32'(SAMPLE_DEPTH)) begin
            cnt_eff = 32'(SAMPLE_DEPTH);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    case (i_item.cmd)
                        CMD_TICK: begin
                            if (r_paused) begin
                                n_state = ST_IDLE;
                            end else if (!r_playing) begin
                                n_state = ST_RD;
                            end else begin
                                n_state = ST_MUL1;
                            end
                        end
                        CMD_JUMP: n_state = i_item.sample_ok ? ST_JRD : ST_IDLE;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_CMP;
            ST_CMP:  n_state = ST_RD;
            ST_RD:   n_state = ST_VAL;
            ST_VAL: begin
                n_state = (seg_rnd && r_stepped && !rng_empty) ? ST_MOD : ST_IDLE;
            end
            ST_MOD:  n_state = mod_done ? ST_IDLE : ST_MOD;
            ST_JRD:  n_state = ST_JSEG;
            ST_JSEG: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_item_pop = take;
        ram_we     = take && (i_item.cmd == CMD_WR_SMP) && i_item.sample_ok;
        load_out   = 1'b0;
        mod_start  = 1'b0;
        out_val    = r_held;
        case (r_state)
            ST_IDLE: begin
                load_out = take && (i_item.cmd == CMD_TICK) && r_paused;
            end
            ST_VAL: begin
                if (seg_rnd && r_stepped) begin
                    mod_start = !rng_empty;
                    load_out  = rng_empty;
                    out_val   = i_cfg.rand_low;
                end else begin
                    load_out = 1'b1;
                    out_val  = seg_rnd ? r_held : store_rdata;
                end
            end
            ST_MOD: begin
                load_out = mod_done;
                out_val  = i_cfg.rand_low + mod_rem;
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= '0;
            r_seg       <= '0;
            r_tick      <= '0;
            r_last      <= '0;
            r_playing   <= 1'b0;
            r_paused    <= 1'b0;
            r_done      <= 1'b0;
            r_held      <= '0;
            r_noise     <= 32'd1;
            r_stepped   <= 1'b0;
            r_load_seg  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < SEGMENT_COUNT; k++) begin
                r_flags[k]  <= 1'b0;
                r_scales[k] <= SCALE_W'(256);
            end
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (load_out) begin
                r_held <= out_val;
            end
            case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        case (i_item.cmd)
                            CMD_TICK: begin
                                if (!r_paused) begin
                                    r_load_seg <= 1'b0;
                                    if (!r_playing) begin
                                        r_playing <= 1'b1;
                                        r_tick    <= '0;
                                        r_last    <= '0;
                                        r_cur     <= '0;
                                        r_seg     <= '0;
                                        r_done    <= 1'b0;
                                        r_stepped <= 1'b1;
                                    end else begin
                                        r_stepped <= 1'b0;
                                        if (r_tick != '1) begin
                                            r_tick <= r_tick + 32'd1;
                                        end
                                    end
                                end
                            end
                            CMD_WR_SEG: begin
                                if (i_item.segment_ok) begin
                                    r_flags[SW'(i_item.index)]  <= i_item.segment_random;
                                    r_scales[SW'(i_item.index)] <= i_item.segment_scale;
                                end
                            end
                            CMD_HOLD:    r_paused  <= 1'b1;
                            CMD_RELEASE: r_paused  <= 1'b0;
                            CMD_STOP:    r_playing <= 1'b0;
                            CMD_JUMP: begin
                                if (i_item.sample_ok) begin
                                    r_cur <= AW'(i_item.index);
                                end
                            end
                            default: begin
                                r_paused <= r_paused;
                            end
                        endcase
                    end
                end
                ST_MUL1: begin
                    r_prod1  <= 32'(i_cfg.step_time) * 32'(i_cfg.time_scale);
                    r_sscale <= (32'(r_seg) < 32'(SEGMENT_COUNT)) ? r_scales[SW'(r_seg)]
                                                                  : 16'd256;
                end
                ST_MUL2: begin
                    r_t8 <= prod2[47:12];
                end
                ST_CMP: begin
                    if (due) begin
                        r_stepped  <= 1'b1;
                        r_load_seg <= 1'b1;
                        r_last     <= r_last + 40'(r_t8);
                        if (!i_cfg.run_reverse) begin
                            if (32'(r_cur) + 32'd1 < cnt_eff) begin
                                r_cur  <= r_cur + AW'(1);
                                r_done <= 1'b0;
                            end else begin
                                r_cur  <= '0;
                                r_done <= 1'b1;
                                r_tick <= '0;
                                r_last <= '0;
                            end
                        end else begin
                            if (r_cur != '0) begin
                                r_cur  <= r_cur - AW'(1);
                                r_done <= 1'b0;
                            end else begin
                                r_cur  <= AW'(cnt_eff - 32'd1);
                                r_done <= 1'b1;
                                r_tick <= '0;
                                r_last <= '0;
                            end
                        end
                    end
                end
                ST_VAL: begin
                    r_seg      <= seg_now;
                    r_load_seg <= 1'b0;
                    if (seg_rnd && r_stepped) begin
                        r_noise <= noise_next;
                    end
                end
                ST_JSEG: begin
                    r_seg <= map_rdata;
                end
                default: begin
                    r_seg <= r_seg;
                end
            endcase
        end
        if (load_out) begin
            r_out_value   <= out_val;
            r_out_sample  <= CW'(r_cur);
            r_out_segment <= seg_now;
            r_out_stepped <= (r_state != ST_IDLE) && r_stepped;
            r_out_wrapped <= r_done;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_out_sample  = r_out_sample[INDEX_W-1:0];
    assign o_out_segment = r_out_segment;
    assign o_stepped     = r_out_stepped;
    assign o_wrapped     = r_out_wrapped;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !r_out_valid)
        else $error("result loaded over a waiting result");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) < 32'(SAMPLE_DEPTH))
        else $error("current sample out of table");

    a_noise_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_noise != '0)
        else $error("noise register stuck at zero");

    a_mod_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_start |=> (r_state == ST_MOD))
        else $error("remainder started outside random step");

endmodule

FILE: src/segment_pattern_player_core.sv
// ----------------------------------------------------------------------------
// segment_pattern_player_core
// Timed player for a loaded sample table with per-segment scaling and noise.
// ----------------------------------------------------------------------------
// Commands enter a two-entry queue and are executed one at a time. A tick
// runs the step check (two multiplies, then a compare) and a table read;
// the first tick only reads the table, and a tick while held only reloads
// the held value. A tick that steps into a random segment with a non-empty
// random range adds the bit-serial remainder of the noise word. A tick is
// only started once the result register is free.
module segment_pattern_player_core import spp_pkg::*; #(
    parameter int SAMPLE_DEPTH  = DEF_SAMPLE_DEPTH,
    parameter int SEGMENT_COUNT = DEF_SEGMENT_COUNT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [2:0]                 i_cmd,
    input  logic [INDEX_W-1:0]         i_index,
    input  logic signed [VALUE_W-1:0]  i_sample_value,
    input  logic [SEG_W-1:0]           i_sample_segment,
    input  logic                       i_segment_random,
    input  logic [SCALE_W-1:0]         i_segment_scale,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [VALUE_W-1:0]  o_out_value,
    output logic [INDEX_W-1:0]         o_out_sample,
    output logic [SEG_W-1:0]           o_out_segment,
    output logic                       o_stepped,
    output logic                       o_wrapped,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFGI_W-1:0]          i_cfg_index,
    input  logic [15:0]                i_cfg_data
);

    t_cfg  r_cfg;
    t_item item;
    logic  item_valid, item_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_count <= COUNT_W'(1);
            r_cfg.step_time    <= 16'd16;
            r_cfg.time_scale   <= 16'd256;
            r_cfg.rand_low     <= '0;
            r_cfg.rand_high    <= VALUE_W'(127);
            r_cfg.run_reverse  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SAMPLE_COUNT: r_cfg.sample_count <= i_cfg_data[COUNT_W-1:0];
                REG_STEP_TIME:    r_cfg.step_time    <= i_cfg_data;
                REG_TIME_SCALE:   r_cfg.time_scale   <= i_cfg_data;
                REG_RAND_LOW:     r_cfg.rand_low     <= i_cfg_data;
                REG_RAND_HIGH:    r_cfg.rand_high    <= i_cfg_data;
                REG_RUN_REVERSE:  r_cfg.run_reverse  <= i_cfg_data[0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    spp_front #(.SAMPLE_DEPTH(SAMPLE_DEPTH), .SEGMENT_COUNT(SEGMENT_COUNT)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_cmd            (i_cmd),
        .i_index          (i_index),
        .i_sample_value   (i_sample_value),
        .i_sample_segment (i_sample_segment),
        .i_segment_random (i_segment_random),
        .i_segment_scale  (i_segment_scale),
        .o_item_valid     (item_valid),
        .o_item           (item),
        .i_item_pop       (item_pop)
    );

    spp_back #(.SAMPLE_DEPTH(SAMPLE_DEPTH), .SEGMENT_COUNT(SEGMENT_COUNT)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_pop    (item_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_out_value   (o_out_value),
        .o_out_sample  (o_out_sample),
        .o_out_segment (o_out_segment),
        .o_stepped     (o_stepped),
        .o_wrapped     (o_wrapped)
    );

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment pattern player core. The whole sample
// table is loaded first. A short directed sequence and random command traffic
// follow, over several register settings. A scoreboard predicts each tick
// result and compares it with what the block pops, field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import spp_pkg::*;

    localparam int          TBL_DEPTH  = 1024;
    localparam int          SEG_CNT    = 16;
    localparam int          WDOG_LIMIT = 20000;
    localparam int          SETTLE     = 60;
    localparam logic [2:0]  CMD_UNUSED = 3'd7;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        sample;
        logic [SEG_W-1:0]          segment;
        logic                      stepped;
        logic                      wrapped;
    } t_tick_result;

    class pattern_scoreboard;
        t_tick_result          expected_q[$];
        int                    errors;
        logic [COUNT_W-1:0]    r_count;
        logic [15:0]           r_step, r_scale;
        logic signed [15:0]    r_lo, r_hi;
        logic                  r_rev;
        logic [15:0]           values[TBL_DEPTH];
        logic [SEG_W-1:0]      seg_of[TBL_DEPTH];
        logic                  seg_rand[SEG_CNT];
        logic [15:0]           seg_scale[SEG_CNT];
        logic [31:0]           ticks;
        logic [39:0]           last_step;
        logic [INDEX_W-1:0]    cur_sample;
        logic [SEG_W-1:0]      cur_seg;
        logic                  playing, paused, done;
        logic [15:0]           held;
        logic [31:0]           noise;

        function new();
            errors = 0;
            r_count = 1; r_step = 16; r_scale = 256; r_lo = 0; r_hi = 127; r_rev = 0;
            foreach (values[k]) begin
                values[k] = 0;
                seg_of[k] = 0;
            end
            foreach (seg_rand[k]) begin
                seg_rand[k] = 0;
                seg_scale[k] = 256;
            end
            ticks = 0; last_step = 0; cur_sample = 0; cur_seg = 0;
            playing = 0; paused = 0; done = 0; held = 0; noise = 1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFGI_W-1:0] idx, logic [15:0] data);
            case (idx)
                REG_SAMPLE_COUNT: r_count = data[COUNT_W-1:0];
                REG_STEP_TIME:    r_step = data;
                REG_TIME_SCALE:   r_scale = data;
                REG_RAND_LOW:     r_lo = data;
                REG_RAND_HIGH:    r_hi = data;
                REG_RUN_REVERSE:  r_rev = data[0];
                default: ;
            endcase
        endfunction

        function logic [15:0] draw_noise();
            logic [31:0] x;
            int          lo, hi;
            x = noise;
            x = x ^ (x << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
            noise = x;
            lo = r_lo;
            hi = r_hi;
            if (hi <= lo) return lo[15:0];
            return 16'(lo + int'(x % 32'(hi - lo)));
        endfunction

        function void note_item(logic [2:0] cmd, logic [INDEX_W-1:0] idx,
                                logic [15:0] sval, logic [SEG_W-1:0] sseg,
                                logic srand, logic [15:0] sscale);
            t_tick_result      r;
            logic              stepped;
            longint unsigned   span, now8;
            int unsigned       cnt;
            logic [15:0]       v;
            stepped = 0;
            case (cmd)
                CMD_WR_SMP: begin
                    values[idx] = sval;
                    seg_of[idx] = sseg;
                    return;
                end
                CMD_WR_SEG: begin
                    if (idx < SEG_CNT) begin
                        seg_rand[idx] = srand;
                        seg_scale[idx] = sscale;
                    end
                    return;
                end
                CMD_HOLD:    begin paused = 1; return; end
                CMD_RELEASE: begin paused = 0; return; end
                CMD_STOP:    begin playing = 0; return; end
                CMD_JUMP: begin
                    cur_sample = idx;
                    cur_seg = seg_of[idx];
                    return;
                end
                CMD_TICK: ;
                default: return;
            endcase
            if (paused) begin
                v = held;
            end else begin
                if (ticks != 32'hFFFF_FFFF) ticks++;
                if (!playing) begin
                    playing = 1; ticks = 0; last_step = 0;
                    cur_sample = 0; cur_seg = 0; done = 0; stepped = 1;
                end else begin
                    span = (longint'(r_step) * longint'(r_scale)
                            * longint'(seg_scale[cur_seg])) >> 12;
                    now8 = longint'(ticks) << 8;
                    if (now8 > longint'(last_step) + span) begin
                        cnt = (r_count == 0) ? 1 : (r_count > TBL_DEPTH) ? TBL_DEPTH : r_count;
                        last_step = last_step + span[39:0];
                        stepped = 1;
                        if (!r_rev) begin
                            if (cur_sample + 1 < cnt) begin
                                cur_sample++;
                                done = 0;
                            end else begin
                                cur_sample = 0; done = 1; ticks = 0; last_step = 0;
                            end
                        end else begin
                            if (cur_sample > 0) begin
                                cur_sample--;
                                done = 0;
                            end else begin
                                cur_sample = INDEX_W'(cnt - 1);
                                done = 1; ticks = 0; last_step = 0;
                            end
                        end
                        cur_seg = seg_of[cur_sample];
                    end
                end
                if (seg_rand[cur_seg]) v = stepped ? draw_noise() : held;
                else v = values[cur_sample];
                held = v;
            end
            r.value = v; r.sample = cur_sample; r.segment = cur_seg;
            r.stepped = stepped; r.wrapped = done;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_tick_result got);
            t_tick_result e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer: value %0d", got.value);
                return;
            end
            e = expected_q.pop_front();
            if (got.value !== e.value || got.sample !== e.sample || got.segment !== e.segment
                || got.stepped !== e.stepped || got.wrapped !== e.wrapped) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp val %0d smp %0d seg %0d st %b wr %b",
                             e.value, e.sample, e.segment, e.stepped, e.wrapped);
                    $display("          got val %0d smp %0d seg %0d st %b wr %b",
                             got.value, got.sample, got.segment, got.stepped, got.wrapped);
                end
            end
        endfunction
    endclass

    logic                      i_clk, i_rst_n;
    logic                      push, full, empty, pop;
    logic [2:0]                i_cmd;
    logic [INDEX_W-1:0]        i_index;
    logic signed [VALUE_W-1:0] i_sample_value;
    logic [SEG_W-1:0]          i_sample_segment;
    logic                      i_segment_random;
    logic [SCALE_W-1:0]        i_segment_scale;
    logic signed [VALUE_W-1:0] o_out_value;
    logic [INDEX_W-1:0]        o_out_sample;
    logic [SEG_W-1:0]          o_out_segment;
    logic                      o_stepped, o_wrapped;
    logic                      i_cfg_valid, o_cfg_ready;
    logic [CFGI_W-1:0]         i_cfg_index;
    logic [15:0]               i_cfg_data;

    pattern_scoreboard sb;
    logic              calm;
    int                stall_cnt = 0;

    segment_pattern_player_core dut (.*);

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        push = 0; pop = 0; i_cfg_valid = 0;
        i_cmd = CMD_TICK; i_index = 0; i_sample_value = 0; i_sample_segment = 0;
        i_segment_random = 0; i_segment_scale = 0; i_cfg_index = REG_SAMPLE_COUNT;
        i_cfg_data = 0;
        calm = 0;
        sb = new();
    end

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side
    initial begin
        t_tick_result got;
        forever begin
            @(negedge i_clk);
            pop = calm || ($urandom_range(99) >= 15);
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got.value = o_out_value; got.sample = o_out_sample;
                got.segment = o_out_segment; got.stepped = o_stepped;
                got.wrapped = o_wrapped;
                sb.check_result(got);
            end
        end
    end

    task automatic send_item(logic [2:0] cmd, logic [INDEX_W-1:0] idx, logic [15:0] sval,
                             logic [SEG_W-1:0] sseg, logic srand, logic [15:0] sscale);
        while (!calm && $urandom_range(99) < 15) begin
            @(negedge i_clk);
            push = 0;
        end
        @(negedge i_clk);
        push = 1;
        i_cmd = cmd; i_index = idx; i_sample_value = sval; i_sample_segment = sseg;
        i_segment_random = srand; i_segment_scale = sscale;
        do @(posedge i_clk); while (full);
        sb.note_item(cmd, idx, sval, sseg, srand, sscale);
    endtask

    task automatic drain();
        @(negedge i_clk);
        push = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFGI_W-1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1; i_cfg_index = idx; i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic apply_cfg(logic [15:0] cnt, logic [15:0] st, logic [15:0] ts,
                             logic [15:0] lo, logic [15:0] hi, logic rev);
        drain();
        write_reg(REG_SAMPLE_COUNT, cnt);
        write_reg(REG_STEP_TIME, st);
        write_reg(REG_TIME_SCALE, ts);
        write_reg(REG_RAND_LOW, lo);
        write_reg(REG_RAND_HIGH, hi);
        write_reg(REG_RUN_REVERSE, {15'd0, rev});
    endtask

    task automatic random_item();
        int          r;
        logic [2:0]  cmd;
        logic [15:0] sc;
        r = $urandom_range(99);
        if (r < 55)      cmd = CMD_TICK;
        else if (r < 68) cmd = CMD_WR_SMP;
        else if (r < 76) cmd = CMD_WR_SEG;
        else if (r < 81) cmd = CMD_HOLD;
        else if (r < 87) cmd = CMD_RELEASE;
        else if (r < 91) cmd = CMD_STOP;
        else if (r < 97) cmd = CMD_JUMP;
        else             cmd = CMD_UNUSED;
        sc = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(512));
        send_item(cmd, (cmd == CMD_WR_SEG && $urandom_range(3) != 0) ?
                  INDEX_W'($urandom_range(15)) : INDEX_W'($urandom),
                  16'($urandom), SEG_W'($urandom), 1'($urandom), sc);
    endtask

    task automatic random_cfg();
        logic [15:0] cnt, st, ts;
        cnt = ($urandom_range(7) == 0) ? 16'($urandom_range(2047)) : 16'($urandom_range(1, 12));
        st  = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        ts  = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        apply_cfg(cnt, st, ts, 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    initial begin
        int k;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // load the whole table so no read ever hits an unwritten entry
        for (k = 0; k < TBL_DEPTH; k++)
            send_item(CMD_WR_SMP, INDEX_W'(k),
                      (k == 0) ? 16'h7FFF : (k == 1) ? 16'h8000 : 16'($urandom),
                      (k < 4) ? SEG_W'(k) : SEG_W'($urandom), 0, 0);

        // directed part
        apply_cfg(16'd3, 16'd1, 16'd0, 16'h8000, 16'h7FFF, 0);
        send_item(CMD_WR_SEG, 10'd0, 0, 0, 1'b0, 16'hFFFF);
        send_item(CMD_WR_SEG, 10'd1, 0, 0, 1'b1, 16'd0);
        send_item(CMD_WR_SEG, 10'd1023, 0, 0, 1'b1, 16'd1);
        send_item(CMD_WR_SMP, 10'd1, 16'h8000, 4'd1, 0, 0);
        for (k = 0; k < 5; k++) send_item(CMD_TICK, 0, 0, 0, 0, 0);
        send_item(CMD_HOLD, 0, 0, 0, 0, 0);
        send_item(CMD_HOLD, 0, 0, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0, 0);
        send_item(CMD_RELEASE, 0, 0, 0, 0, 0);
        send_item(CMD_RELEASE, 0, 0, 0, 0, 0);
        send_item(CMD_JUMP, 10'd1023, 0, 0, 0, 0);
        send_item(CMD_UNUSED, 10'd1023, 16'hFFFF, 4'hF, 1, 16'hFFFF);
        send_item(CMD_TICK, 0, 0, 0, 0, 0);
        send_item(CMD_STOP, 0, 0, 0, 0, 0);
        send_item(CMD_STOP, 0, 0, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0, 0);
        apply_cfg(16'd1024, 16'hFFFF, 16'hFFFF, 16'd5, 16'd5, 1);
        send_item(CMD_TICK, 0, 0, 0, 0, 0);
        send_item(CMD_JUMP, 10'd0, 0, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0, 0, 0);
        apply_cfg(16'd0, 16'd0, 16'd1, 16'h7FFF, 16'h8000, 1);
        for (k = 0; k < 3; k++) send_item(CMD_TICK, 0, 0, 0, 0, 0);
        apply_cfg(16'd2047, 16'd1, 16'd256, 16'hFF00, 16'd100, 0);
        send_item(CMD_JUMP, 10'd1022, 0, 0, 0, 0);
        for (k = 0; k < 3; k++) send_item(CMD_TICK, 0, 0, 0, 0, 0);

        // random part
        for (k = 0; k < 400; k++) begin
            if (k % 80 == 0) random_cfg();
            calm = (k >= 150 && k < 250);
            if (k == 300) begin
                @(negedge i_clk);
                push = 0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            random_item();
        end
        calm = 0;
        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
